@@ hw/rtl/lrct_pkg.sv @@
// ----------------------------------------------------------------------------
// lrct_pkg
// shared types and constants of the lidar return clip and transform block
// ----------------------------------------------------------------------------
package lrct_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int QW = 32;   // quaternion, coordinate and range word
  localparam int LW = 31;   // range limit width
  localparam int DIV_STEPS = 32;

  // register indexes
  localparam logic [2:0] REG_QUAT_X = 3'd0;
  localparam logic [2:0] REG_QUAT_Y = 3'd1;
  localparam logic [2:0] REG_QUAT_Z = 3'd2;
  localparam logic [2:0] REG_QUAT_W = 3'd3;
  localparam logic [2:0] REG_SHIFT_X = 3'd4;
  localparam logic [2:0] REG_SHIFT_Y = 3'd5;
  localparam logic [2:0] REG_SHIFT_Z = 3'd6;
  localparam logic [2:0] REG_RANGE_LIMIT = 3'd7;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic [30:0] RANGE_LIMIT_RST = 31'd1966080;

  typedef logic signed [31:0] coord_t;
  typedef coord_t mat_t [0:8];

  // per-return side data that rides along the pipeline
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        rng;
    logic               clipped;
    logic               hit;
    logic [30:0]        crange;
  } side_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
  } div_lane_t;

endpackage

@@ hw/rtl/lrct_if.sv @@
// ----------------------------------------------------------------------------
// lrct_in_if / lrct_out_if
// valid/ready channels for lidar returns and map points
// ----------------------------------------------------------------------------
interface lrct_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] measured_range;
  logic [7:0]         hit_byte;

  modport source(output valid, point_x, point_y, point_z, measured_range, hit_byte,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, measured_range, hit_byte,
               output ready);
  modport monitor(input valid, ready, point_x, point_y, point_z, measured_range,
                  hit_byte);
endinterface

interface lrct_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] map_x;
  logic signed [31:0] map_y;
  logic signed [31:0] map_z;
  logic [30:0]        limited_range;
  logic               is_hit;

  modport source(output valid, map_x, map_y, map_z, limited_range, is_hit,
                 input ready);
  modport sink(input valid, map_x, map_y, map_z, limited_range, is_hit,
               output ready);
  modport monitor(input valid, ready, map_x, map_y, map_z, limited_range, is_hit);
endinterface

@@ hw/rtl/lidar_return_clip_transform_core.sv @@
// ----------------------------------------------------------------------------
// lidar_return_clip_transform_core
// clips lidar returns to a maximum range and moves them into the map frame
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one lidar return per beat (endpoint, measured range, hit byte)
//   out_ch : one map point per kept return (map x/y/z, clipped range, hit flag)
//   cfg    : write port, cfg_we with cfg_index and cfg_data, no read-back;
//            quaternion, translation and range limit, written while idle
//   returns with a range of zero or less are taken and produce no beat
//   from input beat to output beat the pipeline registers are: capture, the
//     scaling multiply, 32 divider stages (one quotient bit each), then
//     coordinate select, matrix multiply, row sum and translate/saturate
//   one beat per cycle unless out_ch stalls; the divider stages set the depth
//   the rotation matrix follows a config write via the product register
//   when out_ch stalls with a beat waiting, the whole pipeline holds and
//     in_ch.ready drops; nothing is dropped or repeated
//   reset (rst, synchronous) clears all valid bits and loads the identity
//     rotation, zero translation and a 30 m range limit
// ----------------------------------------------------------------------------
module lidar_return_clip_transform_core #(
  parameter int COORD_WIDTH = lrct_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lrct_in_if.sink     in_ch,
  lrct_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [31:0] shift_x, shift_y, shift_z;
  logic [30:0]        range_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x      <= '0;
      quat_y      <= '0;
      quat_z      <= '0;
      quat_w      <= lrct_pkg::Q30_ONE;
      shift_x     <= '0;
      shift_y     <= '0;
      shift_z     <= '0;
      range_limit <= lrct_pkg::RANGE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lrct_pkg::REG_QUAT_X:      quat_x      <= cfg_data;
        lrct_pkg::REG_QUAT_Y:      quat_y      <= cfg_data;
        lrct_pkg::REG_QUAT_Z:      quat_z      <= cfg_data;
        lrct_pkg::REG_QUAT_W:      quat_w      <= cfg_data;
        lrct_pkg::REG_SHIFT_X:     shift_x     <= cfg_data;
        lrct_pkg::REG_SHIFT_Y:     shift_y     <= cfg_data;
        lrct_pkg::REG_SHIFT_Z:     shift_z     <= cfg_data;
        lrct_pkg::REG_RANGE_LIMIT: range_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output beat is waiting
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  lrct_pkg::mat_t  mat;
  logic            clip_valid;
  lrct_pkg::side_t clip_side;
  logic [31:0]     clip_quo [0:2];

  lrct_rotmat u_rotmat (
    .clk    (clk),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z),
    .quat_w (quat_w),
    .mat    (mat)
  );

  lrct_clip u_clip (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_take        (in_ch.valid),
    .point_x        (in_ch.point_x),
    .point_y        (in_ch.point_y),
    .point_z        (in_ch.point_z),
    .measured_range (in_ch.measured_range),
    .hit_byte       (in_ch.hit_byte),
    .range_limit    (range_limit),
    .out_valid      (clip_valid),
    .out_side       (clip_side),
    .out_quo        (clip_quo)
  );

  lrct_xform #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_xform (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (clip_valid),
    .in_side       (clip_side),
    .in_quo        (clip_quo),
    .mat           (mat),
    .shift_x       (shift_x),
    .shift_y       (shift_y),
    .shift_z       (shift_z),
    .out_valid     (out_ch.valid),
    .map_x         (out_ch.map_x),
    .map_y         (out_ch.map_y),
    .map_z         (out_ch.map_z),
    .limited_range (out_ch.limited_range),
    .is_hit        (out_ch.is_hit)
  );

endmodule

@@ hw/rtl/lrct_rotmat.sv @@
// ----------------------------------------------------------------------------
// lrct_rotmat
// rotation matrix from the configured quaternion, two register stages
// ----------------------------------------------------------------------------
module lrct_rotmat (
  input  logic                clk,
  input  logic signed [31:0]  quat_x,
  input  logic signed [31:0]  quat_y,
  input  logic signed [31:0]  quat_z,
  input  logic signed [31:0]  quat_w,
  output lrct_pkg::mat_t      mat
);

  // rounded products, Q.30, up to about 2^32
  logic signed [33:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

  function automatic logic signed [33:0] qprod(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = (64'(a) * 64'(b)) + 64'sd536870912;
    return 34'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [37:0] v);
    if (v > 38'sd1073741824) begin
      return lrct_pkg::Q30_ONE;
    end else if (v < -38'sd1073741824) begin
      return -lrct_pkg::Q30_ONE;
    end
    return 32'(v);
  endfunction

  function automatic logic signed [37:0] two(input logic signed [37:0] v);
    return v <<< 1;
  endfunction

  always_ff @(posedge clk) begin
    xx <= qprod(quat_x, quat_x);
    yy <= qprod(quat_y, quat_y);
    zz <= qprod(quat_z, quat_z);
    xy <= qprod(quat_x, quat_y);
    xz <= qprod(quat_x, quat_z);
    yz <= qprod(quat_y, quat_z);
    wx <= qprod(quat_w, quat_x);
    wy <= qprod(quat_w, quat_y);
    wz <= qprod(quat_w, quat_z);
  end

  always_ff @(posedge clk) begin
    mat[0] <= clamp_unit(38'sd1073741824 - two(38'(yy) + 38'(zz)));
    mat[1] <= clamp_unit(two(38'(xy) - 38'(wz)));
    mat[2] <= clamp_unit(two(38'(xz) + 38'(wy)));
    mat[3] <= clamp_unit(two(38'(xy) + 38'(wz)));
    mat[4] <= clamp_unit(38'sd1073741824 - two(38'(xx) + 38'(zz)));
    mat[5] <= clamp_unit(two(38'(yz) - 38'(wx)));
    mat[6] <= clamp_unit(two(38'(xz) - 38'(wy)));
    mat[7] <= clamp_unit(two(38'(yz) + 38'(wx)));
    mat[8] <= clamp_unit(38'sd1073741824 - two(38'(xx) + 38'(yy)));
  end

endmodule

@@ hw/rtl/lrct_clip.sv @@
// ----------------------------------------------------------------------------
// lrct_clip
// range check and endpoint scaling: capture, multiply, 32-stage divider
// ----------------------------------------------------------------------------
module lrct_clip (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_take,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic signed [31:0]  measured_range,
  input  logic [7:0]          hit_byte,
  input  logic [30:0]         range_limit,
  output logic                out_valid,
  output lrct_pkg::side_t     out_side,
  output logic [31:0]         out_quo [0:2]
);

  localparam int N = lrct_pkg::DIV_STEPS;

  logic            v0;
  lrct_pkg::side_t s0;
  logic            vd [0:N];
  lrct_pkg::side_t sd [0:N];
  lrct_pkg::div_lane_t dl [0:N][0:2];

  logic [31:0] mag [0:2];
  logic [62:0] dvd [0:2];

  // capture stage: drop nonpositive ranges, decide clipping
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_take && !measured_range[31] && (measured_range != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0.px      <= point_x;
      s0.py      <= point_y;
      s0.pz      <= point_z;
      s0.rng     <= measured_range;
      s0.clipped <= measured_range > $signed({1'b0, range_limit});
      s0.hit     <= hit_byte != '0;
      s0.crange  <= (measured_range > $signed({1'b0, range_limit})) ?
                    range_limit : measured_range[30:0];
    end
  end

  // scaling numerator |p| * limit + range / 2
  always_comb begin
    mag[0] = s0.px[31] ? 32'(-s0.px) : s0.px;
    mag[1] = s0.py[31] ? 32'(-s0.py) : s0.py;
    mag[2] = s0.pz[31] ? 32'(-s0.pz) : s0.pz;
    for (int i = 0; i < 3; i++) begin
      dvd[i] = (63'(mag[i]) * 63'(range_limit)) + 63'(s0.rng >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (adv) begin
      vd[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= s0;
      for (int i = 0; i < 3; i++) begin
        dl[0][i].rem <= {1'b0, dvd[i][62:32]};
        dl[0][i].lo  <= dvd[i][31:0];
        dl[0][i].quo <= '0;
      end
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_div
    logic [31:0] trial [0:2];
    logic        ge    [0:2];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {dl[k][i].rem[30:0], dl[k][i].lo[31]};
        ge[i]    = trial[i] >= sd[k].rng;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else if (adv) begin
        vd[k+1] <= vd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k+1] <= sd[k];
        for (int i = 0; i < 3; i++) begin
          dl[k+1][i].rem <= ge[i] ? trial[i] - sd[k].rng : trial[i];
          dl[k+1][i].lo  <= {dl[k][i].lo[30:0], 1'b0};
          dl[k+1][i].quo <= {dl[k][i].quo[30:0], ge[i]};
        end
      end
    end
  end

  assign out_valid  = vd[N];
  assign out_side   = sd[N];
  assign out_quo[0] = dl[N][0].quo;
  assign out_quo[1] = dl[N][1].quo;
  assign out_quo[2] = dl[N][2].quo;

endmodule

@@ hw/rtl/lrct_xform.sv @@
// ----------------------------------------------------------------------------
// lrct_xform
// rotate, round, translate and saturate; last stage is the output register
// ----------------------------------------------------------------------------
module lrct_xform #(
  parameter int COORD_WIDTH = lrct_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  lrct_pkg::side_t     in_side,
  input  logic [31:0]         in_quo [0:2],
  input  lrct_pkg::mat_t      mat,
  input  logic signed [31:0]  shift_x,
  input  logic signed [31:0]  shift_y,
  input  logic signed [31:0]  shift_z,
  output logic                out_valid,
  output logic signed [31:0]  map_x,
  output logic signed [31:0]  map_y,
  output logic signed [31:0]  map_z,
  output logic [30:0]         limited_range,
  output logic                is_hit
);

  localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

  logic               v1, v2, v3;
  logic [31:0]        cr1, cr2, cr3;
  logic               h1, h2, h3;
  logic signed [31:0] p1   [0:2];
  logic signed [63:0] prod [0:8];
  logic signed [35:0] rnd  [0:2];
  logic signed [31:0] orig [0:2];
  logic signed [65:0] acc  [0:2];
  logic signed [65:0] tr   [0:2];
  logic signed [65:0] sat  [0:2];
  logic signed [31:0] shf  [0:2];

  assign orig[0] = in_side.px;
  assign orig[1] = in_side.py;
  assign orig[2] = in_side.pz;
  assign shf[0]  = shift_x;
  assign shf[1]  = shift_y;
  assign shf[2]  = shift_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // stage 1: pick scaled or original coordinate, apply sign
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= !in_side.clipped ? orig[i] :
                 (orig[i][31] ? 32'(-in_quo[i]) : in_quo[i]);
      end
      cr1 <= {1'b0, in_side.crange};
      h1  <= in_side.hit && !in_side.clipped;
    end
  end

  // stage 2: matrix products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r*3+c] <= 64'(mat[r*3+c]) * 64'(p1[c]);
        end
      end
      cr2 <= cr1;
      h2  <= h1;
    end
  end

  // stage 3: row sums rounded to Q19.16
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(prod[r*3]) + 66'(prod[r*3+1]) + 66'(prod[r*3+2]) + 66'sd536870912;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        rnd[r] <= 36'(acc[r] >>> 30);
      end
      cr3 <= cr2;
      h3  <= h2;
    end
  end

  // stage 4: translate and saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tr[r] = 66'(rnd[r]) + 66'(shf[r]);
      if (tr[r] > SAT_HI) begin
        sat[r] = SAT_HI;
      end else if (tr[r] < SAT_LO) begin
        sat[r] = SAT_LO;
      end else begin
        sat[r] = tr[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      map_x         <= sat[0][31:0];
      map_y         <= sat[1][31:0];
      map_z         <= sat[2][31:0];
      limited_range <= cr3[30:0];
      is_hit        <= h3;
    end
  end

endmodule

@@ hw/rtl/lrct_checker.sv @@
// ----------------------------------------------------------------------------
// lrct_checker
// port-level checks on the clip and transform core
// ----------------------------------------------------------------------------
module lrct_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] map_x,
  input logic [30:0] limited_range,
  input logic        is_hit
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(map_x) && $stable(limited_range))
    else $error("output beat changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_hit |-> limited_range != '0)
    else $error("hit reported with zero range");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind lidar_return_clip_transform_core lrct_checker u_lrct_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .map_x         (out_ch.map_x),
  .limited_range (out_ch.limited_range),
  .is_hit        (out_ch.is_hit)
);

@@ verif/lrct_checker.sv @@
// ----------------------------------------------------------------------------
// lrct_scoreboard
// watches the return and map point channels, predicts each map point from the
// accepted return and the current register copy, and compares field by field
// ----------------------------------------------------------------------------
module lrct_scoreboard (
  input  logic        clk,
  input  logic        rst,
  lrct_in_if.monitor  in_mon,
  lrct_out_if.monitor out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_points,
  output int          points_seen,
  output int          clipped_seen
);

  typedef struct {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic [30:0]        crange;
    logic               hit;
  } map_point_t;

  map_point_t expected_points[$];

  logic signed [31:0] qx, qy, qz, qw, tx, ty, tz;
  logic [30:0]        lim_reg;

  function automatic longint floor_q30(longint v);
    return v >>> 30;
  endfunction

  function automatic longint qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return floor_q30(p + (64'sd1 <<< 29));
  endfunction

  function automatic longint unit_clamp(longint v);
    longint one;
    one = 64'sd1 <<< 30;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // p * lim / r, rounded to nearest with ties away from zero
  function automatic longint scale_pt(logic signed [31:0] p, longint lim, longint r);
    longint mag;
    longint q;
    mag = (p < 0) ? -longint'(p) : longint'(p);
    q = (mag * lim + r / 2) / r;
    return (p < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] axis_out(longint a, longint b, longint c,
                                                  longint p0, longint p1, longint p2,
                                                  logic signed [31:0] t);
    longint acc;
    longint v;
    acc = a * p0 + b * p1 + c * p2;
    v = floor_q30(acc + (64'sd1 <<< 29)) + longint'(t);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic map_point_t predict_point(logic signed [31:0] px,
                                               logic signed [31:0] py,
                                               logic signed [31:0] pz,
                                               logic signed [31:0] rng,
                                               logic [7:0] hb);
    map_point_t mp;
    longint r, lim, p0, p1, p2, one;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint m[9];
    logic clip;
    r = longint'(rng);
    lim = longint'({1'b0, lim_reg});
    one = 64'sd1 <<< 30;
    clip = r > lim;
    p0 = clip ? scale_pt(px, lim, r) : longint'(px);
    p1 = clip ? scale_pt(py, lim, r) : longint'(py);
    p2 = clip ? scale_pt(pz, lim, r) : longint'(pz);
    xx = qmul(qx, qx); yy = qmul(qy, qy); zz = qmul(qz, qz);
    xy = qmul(qx, qy); xz = qmul(qx, qz); yz = qmul(qy, qz);
    wx = qmul(qw, qx); wy = qmul(qw, qy); wz = qmul(qw, qz);
    m[0] = unit_clamp(one - 2 * (yy + zz));
    m[1] = unit_clamp(2 * (xy - wz));
    m[2] = unit_clamp(2 * (xz + wy));
    m[3] = unit_clamp(2 * (xy + wz));
    m[4] = unit_clamp(one - 2 * (xx + zz));
    m[5] = unit_clamp(2 * (yz - wx));
    m[6] = unit_clamp(2 * (xz - wy));
    m[7] = unit_clamp(2 * (yz + wx));
    m[8] = unit_clamp(one - 2 * (xx + yy));
    mp.mx = axis_out(m[0], m[1], m[2], p0, p1, p2, tx);
    mp.my = axis_out(m[3], m[4], m[5], p0, p1, p2, ty);
    mp.mz = axis_out(m[6], m[7], m[8], p0, p1, p2, tz);
    mp.crange = clip ? lim_reg : rng[30:0];
    mp.hit = (hb != 8'd0) && !clip;
    return mp;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("map point %0d: %s got %0h want %0h", points_seen, what, got, want);
    fail_count++;
  endtask

  assign pending_points = expected_points.size();

  always @(posedge clk) begin
    map_point_t exp_pt;
    map_point_t pred_pt;
    if (rst) begin
      qx <= '0; qy <= '0; qz <= '0; qw <= lrct_pkg::Q30_ONE;
      tx <= '0; ty <= '0; tz <= '0;
      lim_reg <= lrct_pkg::RANGE_LIMIT_RST;
      expected_points.delete();
      fail_count <= 0;
      points_seen <= 0;
      clipped_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrct_pkg::REG_QUAT_X:      qx <= cfg_data;
          lrct_pkg::REG_QUAT_Y:      qy <= cfg_data;
          lrct_pkg::REG_QUAT_Z:      qz <= cfg_data;
          lrct_pkg::REG_QUAT_W:      qw <= cfg_data;
          lrct_pkg::REG_SHIFT_X:     tx <= cfg_data;
          lrct_pkg::REG_SHIFT_Y:     ty <= cfg_data;
          lrct_pkg::REG_SHIFT_Z:     tz <= cfg_data;
          lrct_pkg::REG_RANGE_LIMIT: lim_reg <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready && in_mon.measured_range > 0) begin
        pred_pt = predict_point(in_mon.point_x, in_mon.point_y, in_mon.point_z,
                                in_mon.measured_range, in_mon.hit_byte);
        expected_points = {expected_points, pred_pt};
        if (in_mon.measured_range > $signed({1'b0, lim_reg})) clipped_seen <= clipped_seen + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        points_seen <= points_seen + 1;
        if (expected_points.size() == 0) begin
          report("unexpected beat", 64'd0, 64'd0);
        end else begin
          exp_pt = expected_points.pop_front();
          if (out_mon.map_x !== exp_pt.mx)
            report("map_x", 64'(out_mon.map_x), 64'(exp_pt.mx));
          if (out_mon.map_y !== exp_pt.my)
            report("map_y", 64'(out_mon.map_y), 64'(exp_pt.my));
          if (out_mon.map_z !== exp_pt.mz)
            report("map_z", 64'(out_mon.map_z), 64'(exp_pt.mz));
          if (out_mon.limited_range !== exp_pt.crange)
            report("limited_range", 64'(out_mon.limited_range), 64'(exp_pt.crange));
          if (out_mon.is_hit !== exp_pt.hit)
            report("is_hit", 64'(out_mon.is_hit), 64'(exp_pt.hit));
        end
      end
    end
  end
endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives lidar returns and register settings into the clip and transform
// core under random idling on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;

  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 325;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        sink_ready = 1'b0;
  logic        calm = 1'b0;   // no idling in the last stretch
  int          cycle_count = 0;
  int          returns_sent = 0;
  int          fail_count, pending_points, points_seen, clipped_seen;

  lrct_in_if  in_ch();
  lrct_out_if out_ch();

  lidar_return_clip_transform_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lrct_scoreboard u_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch.monitor), .out_mon(out_ch.monitor),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_points(pending_points),
    .points_seen(points_seen), .clipped_seen(clipped_seen)
  );

  // 4 unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lidar_return_clip_transform_core: mismatch");
      $finish;
    end
  end

  // map point receiver: ready drops at random outside the calm stretch
  assign out_ch.ready = sink_ready;
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3);
        sink_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sink_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // idle input channel, all fields known from time zero
  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.measured_range = '0;
    in_ch.hit_byte = '0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one return beat; a gap of idle cycles may come first
  task automatic send_return(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] rng,
                             input logic [7:0] hb);
    int gap;
    if (!calm && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    in_ch.measured_range <= rng;
    in_ch.hit_byte <= hb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    returns_sent++;
  endtask

  task automatic drain_points();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    // dropped returns may still be in flight
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7fff_fffc | $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] any_range();
    case ($urandom_range(0, 9))
      0: return -$signed($urandom_range(0, 32'h7fff_ffff));
      1: return 32'd0;
      2: return $urandom_range(1, 32'h7fff_ffff);
      3: return 32'h7fff_ffff;
      default: return $urandom_range(1, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] any_quat_part();
    case ($urandom_range(0, 3))
      0: return 32'h4000_0000;
      1: return 32'hc000_0000;
      default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  // register setting for a phase: extremes, a turn about z, a zero limit, random values
  task automatic load_setting(input int phase);
    logic [31:0] lim;
    case (phase)
      0: begin
        write_reg(lrct_pkg::REG_QUAT_X, 32'h4000_0000);
        write_reg(lrct_pkg::REG_QUAT_Y, 32'hc000_0000);
        write_reg(lrct_pkg::REG_QUAT_Z, 32'h4000_0000);
        write_reg(lrct_pkg::REG_QUAT_W, 32'hc000_0000);
        write_reg(lrct_pkg::REG_SHIFT_X, 32'h7fff_ffff);
        write_reg(lrct_pkg::REG_SHIFT_Y, 32'h8000_0000);
        write_reg(lrct_pkg::REG_SHIFT_Z, 32'h0000_0000);
        write_reg(lrct_pkg::REG_RANGE_LIMIT, 32'h7fff_ffff);
      end
      1: begin
        // quarter turn about z, narrow limit
        write_reg(lrct_pkg::REG_QUAT_X, 32'd0);
        write_reg(lrct_pkg::REG_QUAT_Y, 32'd0);
        write_reg(lrct_pkg::REG_QUAT_Z, 32'h2d41_3ccd);
        write_reg(lrct_pkg::REG_QUAT_W, 32'h2d41_3ccd);
        write_reg(lrct_pkg::REG_SHIFT_X, 32'h0001_0000);
        write_reg(lrct_pkg::REG_SHIFT_Y, 32'hffff_0000);
        write_reg(lrct_pkg::REG_SHIFT_Z, 32'h0000_8000);
        write_reg(lrct_pkg::REG_RANGE_LIMIT, 32'd1);
      end
      2: begin
        // zero limit: every kept return is clipped to nothing
        write_reg(lrct_pkg::REG_RANGE_LIMIT, 32'd0);
      end
      default: begin
        write_reg(lrct_pkg::REG_QUAT_X, any_quat_part());
        write_reg(lrct_pkg::REG_QUAT_Y, any_quat_part());
        write_reg(lrct_pkg::REG_QUAT_Z, any_quat_part());
        write_reg(lrct_pkg::REG_QUAT_W, any_quat_part());
        write_reg(lrct_pkg::REG_SHIFT_X, any_coord());
        write_reg(lrct_pkg::REG_SHIFT_Y, any_coord());
        write_reg(lrct_pkg::REG_SHIFT_Z, any_coord());
        lim = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 32'h0040_0000) : $urandom();
        write_reg(lrct_pkg::REG_RANGE_LIMIT, lim);
      end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed returns at reset settings: identity, 30 m limit
    send_return(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 8'h01);
    send_return(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h001e_0000, 8'hff);
    send_return(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h001e_0001, 8'h80);
    send_return(32'h0010_0000, 32'hfff0_0000, 32'h0000_0001, 32'h7fff_ffff, 8'h00);
    send_return(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h01);
    send_return(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 8'h01);
    send_return(32'hffff_ffff, 32'h0000_0001, 32'h0000_0003, 32'h003c_0000, 8'h01);
    send_return(32'h0000_0001, 32'hffff_ffff, 32'h0000_0002, 32'h0000_0001, 8'h00);
    send_return(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'h001d_ffff, 8'h55);
    send_return(32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0, 32'h5555_5555, 8'haa);
    send_return(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 8'hff);
    drain_points();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_setting(ph);
      // a few directed beats under each new setting
      send_return(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 8'h01);
      send_return(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 8'h01);
      if (ph == PHASES - 1) calm = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_return(any_coord(), any_coord(), any_coord(), any_range(), 8'($urandom()));
      drain_points();
    end

    $display("sent %0d returns over %0d register settings", returns_sent, PHASES + 1);
    $display("checked %0d map points, %0d of them range clipped", points_seen, clipped_seen);
    if (fail_count == 0) begin
      $display("lidar_return_clip_transform_core: match");
    end else begin
      $display("lidar_return_clip_transform_core: mismatch");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/lrct_pkg.sv
hw/rtl/lrct_if.sv
hw/rtl/lrct_rotmat.sv
hw/rtl/lrct_clip.sv
hw/rtl/lrct_xform.sv
hw/rtl/lidar_return_clip_transform_core.sv
hw/rtl/lrct_checker.sv
verif/lrct_checker.sv
verif/testbench.sv
